// File: design/lpf_pkg.sv
// shared constants, types and tables of the lookahead path follower
package lpf_pkg;
   localparam int PATH_DEPTH   = 1024;
   localparam int CORDIC_STEPS = 16;
   localparam int AW           = $clog2(PATH_DEPTH);
   localparam int LW           = $clog2(PATH_DEPTH + 1);
   localparam int SW           = $clog2(CORDIC_STEPS + 1);

   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
   localparam logic signed [27:0] HALF_PI    = 28'sd26353589;
   localparam logic [15:0]        TURN_CAP   = 16'd16384;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_NO_GOAL  = 3'd0,
      ST_NO_PATH  = 3'd1,
      ST_REACHED  = 3'd2,
      ST_OBSTACLE = 3'd3,
      ST_DRIVING  = 3'd4,
      ST_LOADED   = 3'd5,
      ST_FULL     = 3'd6
   } status_type;

   localparam logic [2:0] REG_GOAL_TOL  = 3'd0;
   localparam logic [2:0] REG_OBST_THR  = 3'd1;
   localparam logic [2:0] REG_CRUISE    = 3'd2;
   localparam logic [2:0] REG_TURN_LIM  = 3'd3;
   localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

   localparam logic signed [27:0] ATAN_Q24 [24] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
   };
endpackage

// File: design/lpf_ram.sv
// generic simple dual port ram with registered read
module lpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/lookahead_path_follower.sv
// lookahead path follower top level: waypoint store, scan sequencer, cordic bearing;
// clear, append, no goal and no path go straight to the output; goal reached and obstacle end
// after the goal check read; a driving tick reads one waypoint at a time (goal check, nearest scan
// from the saved index to the end, lookahead scan from the nearest), then runs CORDIC_STEPS
// rotations, none when the target sits on the robot; one ram read port and one squarer serve
// the scans: one word at a time, the next is taken once the result is handed over; reset
module lookahead_path_follower (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_mode,
   input  logic [23:0]  req_pos_x,
   input  logic [23:0]  req_pos_y,
   input  logic [14:0]  req_heading,
   input  logic [15:0]  req_front_range,
   input  logic         req_goal_active,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_status,
   output logic [11:0]  rsp_speed_cmd,
   output logic [15:0]  rsp_turn_cmd,
   output logic [lpf_pkg::AW-1:0] rsp_target_index,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   // (synchronous) empties the path, clears progress and loads register defaults
   import lpf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_SQ, S_CMP, S_ROT, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      P_GOAL, P_NEAR, P_LOOK
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;

   // configuration registers
   logic [15:0] goal_tol_ff, obst_thr_ff, look_ff;
   logic [11:0] cruise_ff;
   logic [14:0] turn_lim_ff;

   // path state
   logic [LW-1:0] path_len_ff;
   logic [AW-1:0] prog_ff;
   logic          follow_ff;

   // latched tick word
   logic signed [23:0] px_ff, py_ff;
   logic signed [14:0] hd_ff;
   logic [15:0]        front_ff;

   // scan registers
   logic [AW-1:0]      idx_ff, near_ff;
   logic [50:0]        best_ff;
   logic signed [24:0] dx_ff, dy_ff;
   logic [49:0]        sqx_ff, sqy_ff;

   // cordic registers
   logic signed [47:0] cx_ff, cy_ff;
   logic signed [27:0] z_ff;
   logic [SW-1:0]      step_ff;

   // pending result
   logic [2:0]    res_status_ff;
   logic [11:0]   res_speed_ff;
   logic [15:0]   res_turn_ff;
   logic [AW-1:0] res_tgt_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [11:0]   rsp_speed_ff;
   logic [15:0]   rsp_turn_ff;
   logic [AW-1:0] rsp_tgt_ff;

   // waypoint ram, x in the upper half
   logic          ram_we_in;
   logic [AW-1:0] ram_waddr_in, ram_raddr_in;
   logic [47:0]   ram_wdata_in, ram_rdata;

   logic [AW-1:0] last_idx;
   logic          req_take;
   mode_type      req_mode_t;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_take   = req_valid && req_ready;
   assign req_mode_t = mode_type'(req_mode);
   assign last_idx   = AW'(path_len_ff - LW'(1));

   assign ram_we_in    = req_take && (req_mode_t == MODE_APPEND)
                         && (path_len_ff < LW'(PATH_DEPTH));
   assign ram_waddr_in = path_len_ff[AW-1:0];
   assign ram_wdata_in = {req_pos_x, req_pos_y};
   assign ram_raddr_in = idx_ff;

   lpf_ram #(.WIDTH(48), .DEPTH(PATH_DEPTH)) u_wp_ram (
      .clock   (clock),
      .wr_en   (ram_we_in),
      .wr_addr (ram_waddr_in),
      .wr_data (ram_wdata_in),
      .rd_addr (ram_raddr_in),
      .rd_data (ram_rdata)
   );

   // difference vector from robot to the waypoint just read
   logic signed [24:0] dx_in, dy_in;
   assign dx_in = 25'(signed'(ram_rdata[47:24])) - 25'(px_ff);
   assign dy_in = 25'(signed'(ram_rdata[23:0])) - 25'(py_ff);

   // squared distance and thresholds
   logic [50:0] dist_in;
   logic [31:0] tol2, look2;
   assign dist_in = 51'(sqx_ff) + 51'(sqy_ff);
   assign tol2    = 32'(goal_tol_ff) * 32'(goal_tol_ff);
   assign look2   = 32'(look_ff) * 32'(look_ff);

   // start of the nearest search, stale index pinned to the end
   logic [AW-1:0] start_idx;
   assign start_idx = (LW'(prog_ff) > LW'(last_idx)) ? last_idx : prog_ff;

   // cordic prerotation into the right half plane, scaled by 2^20
   logic signed [47:0] cx0, cy0;
   logic signed [27:0] z0;
   always_comb begin
      if (dx_ff < 0) begin
         if (dy_ff >= 0) begin
            cx0 = 48'(dy_ff);
            cy0 = -48'(dx_ff);
            z0  = HALF_PI;
         end else begin
            cx0 = -48'(dy_ff);
            cy0 = 48'(dx_ff);
            z0  = -HALF_PI;
         end
      end else begin
         cx0 = 48'(dx_ff);
         cy0 = 48'(dy_ff);
         z0  = '0;
      end
   end

   // one cordic micro rotation
   logic signed [47:0] shx, shy;
   logic [4:0]         sh_amt;
   assign sh_amt = 5'(step_ff);
   assign shx    = cx_ff >>> sh_amt;
   assign shy    = cy_ff >>> sh_amt;

   // bearing rounding, heading error wrap and turn clamp
   logic signed [27:0] z_round;
   logic signed [17:0] bear, a0, a1, a2, a3, a4, turn2;
   logic signed [15:0] lim, turn_in;
   assign z_round = (z_ff + 28'sd2048) >>> 12;
   assign bear    = 18'(z_round);
   assign a0      = bear - 18'(hd_ff);
   assign a1      = (a0 > PI_Q12) ? a0 - TWO_PI_Q12 : a0;
   assign a2      = (a1 <= -PI_Q12) ? a1 + TWO_PI_Q12 : a1;
   assign a3      = (a2 > PI_Q12) ? a2 - TWO_PI_Q12 : a2;
   assign a4      = (a3 <= -PI_Q12) ? a3 + TWO_PI_Q12 : a3;
   assign turn2   = a4 <<< 1;
   assign lim     = signed'((16'(turn_lim_ff) > TURN_CAP) ? TURN_CAP : 16'(turn_lim_ff));
   always_comb begin
      if (turn2 > 18'(lim)) begin
         turn_in = lim;
      end else if (turn2 < -18'(lim)) begin
         turn_in = -lim;
      end else begin
         turn_in = 16'(turn2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_GOAL;
         path_len_ff  <= '0;
         prog_ff      <= '0;
         follow_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         goal_tol_ff  <= 16'd410;
         obst_thr_ff  <= 16'd358;
         cruise_ff    <= 12'd410;
         turn_lim_ff  <= 15'd2048;
         look_ff      <= 16'd614;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               REG_GOAL_TOL:  goal_tol_ff <= csr_wdata;
               REG_OBST_THR:  obst_thr_ff <= csr_wdata;
               REG_CRUISE:    cruise_ff   <= csr_wdata[11:0];
               REG_TURN_LIM:  turn_lim_ff <= csr_wdata[14:0];
               REG_LOOKAHEAD: look_ff     <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  px_ff         <= signed'(req_pos_x);
                  py_ff         <= signed'(req_pos_y);
                  hd_ff         <= signed'(req_heading);
                  front_ff      <= req_front_range;
                  res_speed_ff  <= '0;
                  res_turn_ff   <= '0;
                  res_tgt_ff    <= '0;
                  case (req_mode_t)
                     MODE_CLEAR: begin
                        path_len_ff   <= '0;
                        prog_ff       <= '0;
                        follow_ff     <= 1'b0;
                        res_status_ff <= ST_NO_PATH;
                        state_ff      <= S_OUT;
                     end
                     MODE_APPEND: begin
                        if (path_len_ff < LW'(PATH_DEPTH)) begin
                           path_len_ff   <= path_len_ff + LW'(1);
                           follow_ff     <= 1'b1;
                           res_status_ff <= ST_LOADED;
                           res_tgt_ff    <= path_len_ff[AW-1:0];
                        end else begin
                           res_status_ff <= ST_FULL;
                        end
                        state_ff <= S_OUT;
                     end
                     MODE_TICK: begin
                        if (!req_goal_active) begin
                           res_status_ff <= ST_NO_GOAL;
                           state_ff      <= S_OUT;
                        end else if (!follow_ff || path_len_ff == '0) begin
                           res_status_ff <= ST_NO_PATH;
                           state_ff      <= S_OUT;
                        end else begin
                           // goal check reads the last waypoint first
                           idx_ff   <= last_idx;
                           phase_ff <= P_GOAL;
                           state_ff <= S_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: begin
               state_ff <= S_SQ;
            end
            S_SQ: begin
               dx_ff    <= dx_in;
               dy_ff    <= dy_in;
               sqx_ff   <= 50'(dx_in * dx_in);
               sqy_ff   <= 50'(dy_in * dy_in);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               case (phase_ff)
                  P_GOAL: begin
                     if (dist_in < 51'(tol2)) begin
                        follow_ff     <= 1'b0;
                        res_status_ff <= ST_REACHED;
                        state_ff      <= S_OUT;
                     end else if (front_ff < obst_thr_ff) begin
                        res_status_ff <= ST_OBSTACLE;
                        state_ff      <= S_OUT;
                     end else begin
                        idx_ff   <= start_idx;
                        near_ff  <= start_idx;
                        best_ff  <= '1;
                        phase_ff <= P_NEAR;
                        state_ff <= S_RD;
                     end
                  end
                  P_NEAR: begin
                     // first minimum wins on ties
                     logic [AW-1:0] near_nx;
                     near_nx = near_ff;
                     if (dist_in < best_ff) begin
                        best_ff <= dist_in;
                        near_nx = idx_ff;
                     end
                     near_ff <= near_nx;
                     if (idx_ff == last_idx) begin
                        prog_ff  <= near_nx;
                        idx_ff   <= near_nx;
                        phase_ff <= P_LOOK;
                     end else begin
                        idx_ff <= idx_ff + AW'(1);
                     end
                     state_ff <= S_RD;
                  end
                  default: begin
                     if (dist_in >= 51'(look2) || idx_ff == last_idx) begin
                        res_tgt_ff <= idx_ff;
                        step_ff    <= '0;
                        if (dx_ff == '0 && dy_ff == '0) begin
                           z_ff     <= '0;
                           state_ff <= S_FIN;
                        end else begin
                           cx_ff    <= cx0 <<< 20;
                           cy_ff    <= cy0 <<< 20;
                           z_ff     <= z0;
                           state_ff <= S_ROT;
                        end
                     end else begin
                        idx_ff   <= idx_ff + AW'(1);
                        state_ff <= S_RD;
                     end
                  end
               endcase
            end
            S_ROT: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + shy;
                  cy_ff <= cy_ff - shx;
                  z_ff  <= z_ff + ATAN_Q24[sh_amt];
               end else begin
                  cx_ff <= cx_ff - shy;
                  cy_ff <= cy_ff + shx;
                  z_ff  <= z_ff - ATAN_Q24[sh_amt];
               end
               if (step_ff == SW'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_FIN;
               end
               step_ff <= step_ff + SW'(1);
            end
            S_FIN: begin
               res_status_ff <= ST_DRIVING;
               res_speed_ff  <= cruise_ff;
               res_turn_ff   <= turn_in;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_speed_ff  <= res_speed_ff;
                  rsp_turn_ff   <= res_turn_ff;
                  rsp_tgt_ff    <= res_tgt_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_speed_cmd    = rsp_speed_ff;
   assign rsp_turn_cmd     = rsp_turn_ff;
   assign rsp_target_index = rsp_tgt_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      path_len_ff <= LW'(PATH_DEPTH))
      else $error("path length beyond depth");
   a_read_in_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> LW'(idx_ff) < path_len_ff)
      else $error("waypoint read outside the loaded path");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_take && req_mode_t == MODE_CLEAR |=> path_len_ff == '0 && !follow_ff)
      else $error("clear did not empty the path");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_status_ff))
      else $error("pending result word dropped");
`endif
endmodule

// File: verif/tb_lookahead_path_follower.sv
// testbench of the lookahead path follower: random path loads and pose ticks vs a predictor
module tb_lookahead_path_follower;
   import lpf_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [14:0] heading;
      logic [15:0] front_range;
      logic        goal_active;
   } pose_word_type;

   typedef struct {
      status_type  status;
      logic [11:0] speed_cmd;
      logic [15:0] turn_cmd;
      logic [9:0]  target_index;
   } steer_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [1:0]   req_mode = 2'd0;
   logic [23:0]  req_pos_x = '0;
   logic [23:0]  req_pos_y = '0;
   logic [14:0]  req_heading = '0;
   logic [15:0]  req_front_range = '0;
   logic         req_goal_active = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [2:0]   rsp_status;
   logic [11:0]  rsp_speed_cmd;
   logic [15:0]  rsp_turn_cmd;
   logic [AW-1:0] rsp_target_index;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   lookahead_path_follower uut (.*);

   always #4 clock = ~clock;

   // predictor state
   logic signed [23:0] path_x [PATH_DEPTH];
   logic signed [23:0] path_y [PATH_DEPTH];
   int unsigned path_len, progress;
   bit          following;
   int unsigned goal_tol, obst_thr, cruise, turn_lim, look_dist;

   pose_word_type  pending_words [$];
   steer_word_type expected_steer [$];
   int          fail_count = 0;
   int          rsp_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   longint      cycle_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
      fail_count++;
   endtask

   function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = bx - ax;
      dy = by - ay;
      return dx * dx + dy * dy;
   endfunction

   // floor shift, same as the hardware arithmetic shift
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // bearing in 2^-12 rad, vectoring cordic in 2^-24 rad
   function automatic int bearing_q12(longint y, longint x);
      longint cx, cy, z, nx;
      int n;
      z = 0;
      n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            cx = y; cy = -x; z = HALF_PI;
         end else begin
            cx = -y; cy = x; z = -HALF_PI;
         end
      end else begin
         cx = x; cy = y;
      end
      cx = cx * 1048576;
      cy = cy * 1048576;
      for (int i = 0; i < n; i++) begin
         if (cy > 0) begin
            nx = cx + shr_floor(cy, i); cy = cy - shr_floor(cx, i); z += ATAN_Q24[i];
         end else begin
            nx = cx - shr_floor(cy, i); cy = cy + shr_floor(cx, i); z -= ATAN_Q24[i];
         end
         cx = nx;
      end
      return int'(shr_floor(z + 2048, 12));
   endfunction

   function automatic steer_word_type steer_result(input pose_word_type w);
      steer_word_type r;
      longint px, py, best, d, tol2, look2;
      int unsigned last, start, nearest, tgt;
      int alpha, lim, turn;
      r = '{ST_NO_PATH, '0, '0, '0};
      px = longint'($signed(w.pos_x));
      py = longint'($signed(w.pos_y));
      if (w.mode == MODE_CLEAR) begin
         path_len = 0; progress = 0; following = 0;
         return r;
      end
      if (w.mode == MODE_APPEND) begin
         if (path_len >= PATH_DEPTH) begin
            r.status = ST_FULL;
            return r;
         end
         path_x[path_len] = w.pos_x;
         path_y[path_len] = w.pos_y;
         r.status = ST_LOADED;
         r.target_index = path_len[9:0];
         path_len++;
         following = 1;
         return r;
      end
      if (!w.goal_active) begin
         r.status = ST_NO_GOAL;
         return r;
      end
      if (!following || path_len == 0) return r;
      last = path_len - 1;
      tol2 = longint'(goal_tol) * goal_tol;
      if (sq_dist(px, py, path_x[last], path_y[last]) < tol2) begin
         following = 0;
         r.status = ST_REACHED;
         return r;
      end
      if (w.front_range < obst_thr) begin
         r.status = ST_OBSTACLE;
         return r;
      end
      start = (progress > last) ? last : progress;
      nearest = start;
      best = 64'h7fff_ffff_ffff_ffff;
      for (int unsigned i = start; i <= last; i++) begin
         d = sq_dist(px, py, path_x[i], path_y[i]);
         if (d < best) begin
            best = d; nearest = i;
         end
      end
      progress = nearest;
      look2 = longint'(look_dist) * look_dist;
      tgt = nearest;
      for (int unsigned i = nearest; i <= last; i++) begin
         tgt = i;
         if (sq_dist(px, py, path_x[i], path_y[i]) >= look2) break;
      end
      alpha = bearing_q12(longint'(path_y[tgt]) - py, longint'(path_x[tgt]) - px)
              - int'($signed(w.heading));
      for (int i = 0; i < 2; i++) begin
         if (alpha > PI_Q12) alpha -= TWO_PI_Q12;
         if (alpha <= -PI_Q12) alpha += TWO_PI_Q12;
      end
      lim = (turn_lim > TURN_CAP) ? TURN_CAP : turn_lim;
      turn = alpha * 2;
      if (turn > lim) turn = lim;
      if (turn < -lim) turn = -lim;
      r.status = ST_DRIVING;
      r.speed_cmd = cruise[11:0];
      r.turn_cmd = turn[15:0];
      r.target_index = tgt[9:0];
      return r;
   endfunction

   bit word_taken = 0;
   always @(posedge clock) begin
      cycle_count++;
      word_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         // an unknown mode gives no response and leaves the state alone
         if (pending_words[0].mode != MODE_NONE)
            expected_steer.insert(expected_steer.size(), steer_result(pending_words[0]));
         void'(pending_words.pop_front());
      end
      // monitor
      if (!reset && rsp_valid && rsp_ready) begin
         steer_word_type want;
         rsp_count++;
         if (expected_steer.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, -1);
         end else begin
            want = expected_steer.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_speed_cmd != want.speed_cmd)
               report_mismatch("speed_cmd", rsp_speed_cmd, want.speed_cmd);
            if (rsp_turn_cmd != want.turn_cmd)
               report_mismatch("turn_cmd", $signed(rsp_turn_cmd), $signed(want.turn_cmd));
            if (rsp_target_index != want.target_index)
               report_mismatch("target_index", rsp_target_index, want.target_index);
         end
      end
      if (cycle_count > 64'd4_000_000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // drive at the falling edge; valid stays up with a stable word until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (!req_valid || word_taken) begin
            if (pending_words.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               req_valid       <= 1'b1;
               req_mode        <= pending_words[0].mode;
               req_pos_x       <= pending_words[0].pos_x;
               req_pos_y       <= pending_words[0].pos_y;
               req_heading     <= pending_words[0].heading;
               req_front_range <= pending_words[0].front_range;
               req_goal_active <= pending_words[0].goal_active;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic queue_word(input mode_type m, input int x, input int y, input int hd,
                             input int fr, input bit g);
      pose_word_type w;
      w.mode = m;
      w.pos_x = x[23:0];
      w.pos_y = y[23:0];
      w.heading = hd[14:0];
      w.front_range = fr[15:0];
      w.goal_active = g;
      pending_words.insert(pending_words.size(), w);
   endtask

   // wait until every queued word went out and every response came back
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_steer.size() != 0)
         @(posedge clock);
      // a mode 3 word gives no response, so leave room for the block to settle
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         REG_GOAL_TOL:  goal_tol = val & 16'hffff;
         REG_OBST_THR:  obst_thr = val & 16'hffff;
         REG_CRUISE:    cruise = val & 12'hfff;
         REG_TURN_LIM:  turn_lim = val & 15'h7fff;
         REG_LOOKAHEAD: look_dist = val & 16'hffff;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int rand_pos(input int spread);
      return $urandom_range(2 * spread) - spread;
   endfunction

   // a well-formed path near a center, then ticks along it
   task automatic queue_path_run(input int n_pts, input int n_ticks, input int spread);
      int cx, cy, step;
      cx = rand_pos(8000000);
      cy = rand_pos(8000000);
      step = $urandom_range(spread);
      if ($urandom_range(3) != 0) queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < n_pts; i++)
         queue_word(MODE_APPEND, cx + i * step + rand_pos(200), cy + rand_pos(spread), 0, 0, 0);
      for (int i = 0; i < n_ticks; i++)
         queue_word(MODE_TICK, cx + $urandom_range(n_pts * step + 1) + rand_pos(300),
                    cy + rand_pos(spread), $urandom_range(25736) - 12868,
                    ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(65535),
                    $urandom_range(15) != 0);
   endtask

   initial begin
      goal_tol = 410; obst_thr = 358; cruise = 410; turn_lim = 2048; look_dist = 614;
      path_len = 0; progress = 0; following = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of every field, each mode and each stop reason
      queue_word(MODE_TICK, 0, 0, 0, 65535, 1'b0);
      queue_word(MODE_TICK, 0, 0, 0, 65535, 1'b1);
      queue_word(MODE_APPEND, -8388608, 8388607, 0, 0, 0);
      queue_word(MODE_APPEND, 8388607, -8388608, 0, 0, 0);
      queue_word(MODE_APPEND, 100, 100, 0, 0, 0);
      queue_word(MODE_TICK, 0, 0, 12868, 65535, 1'b1);
      queue_word(MODE_TICK, 0, 0, -12868, 0, 1'b1);
      queue_word(MODE_TICK, -8388608, -8388608, -12868, 65535, 1'b1);
      queue_word(MODE_TICK, 8388607, 8388607, 12868, 65535, 1'b1);
      queue_word(MODE_NONE, 8388607, -1, -1, 65535, 1'b1);
      queue_word(MODE_TICK, 100, 100, 0, 65535, 1'b1);
      queue_word(MODE_TICK, 100, 100, 0, 65535, 1'b1);
      queue_word(MODE_CLEAR, -1, -1, -1, 65535, 1'b1);
      queue_word(MODE_TICK, 5, 5, 0, 65535, 1'b1);
      queue_word(MODE_APPEND, 4000, 0, 0, 0, 0);
      queue_word(MODE_APPEND, 4000, 0, 0, 0, 0);
      queue_word(MODE_TICK, 4000, 1000, 100, 65535, 1'b1);
      drain();
      // zero lookahead and tolerance: target may sit exactly on the robot
      write_csr(REG_GOAL_TOL, 0);
      write_csr(REG_LOOKAHEAD, 0);
      write_csr(REG_TURN_LIM, 32767);
      write_csr(REG_CRUISE, 4095);
      write_csr(REG_OBST_THR, 65535);
      queue_word(MODE_CLEAR, 0, 0, 0, 0, 0);
      queue_word(MODE_APPEND, 0, 0, 0, 0, 0);
      queue_word(MODE_APPEND, 50, 0, 0, 0, 0);
      queue_word(MODE_TICK, 0, 0, 12000, 65534, 1'b1);
      drain();
      write_csr(REG_OBST_THR, 0);
      queue_word(MODE_TICK, 0, 0, -12000, 0, 1'b1);
      queue_word(MODE_TICK, 0, 0, 12868, 0, 1'b1);
      drain();

      // longer path with no turn allowed and a lookahead past every waypoint
      write_csr(REG_TURN_LIM, 0);
      write_csr(REG_GOAL_TOL, 1);
      write_csr(REG_LOOKAHEAD, 65535);
      queue_word(MODE_CLEAR, 0, 0, 0, 0, 0);
      for (int i = 0; i < 24; i++) queue_word(MODE_APPEND, i * 64, i & 7, 0, 0, 0);
      queue_word(MODE_TICK, 0, 0, 0, 65535, 1'b1);
      queue_word(MODE_TICK, 30000, 0, 0, 65535, 1'b1);
      // robot behind the start of a fresh path after a clear
      queue_word(MODE_CLEAR, 0, 0, 0, 0, 0);
      queue_word(MODE_APPEND, 1000, 1000, 0, 0, 0);
      queue_word(MODE_APPEND, 2000, 1000, 0, 0, 0);
      queue_word(MODE_TICK, 0, 0, 0, 65535, 1'b1);
      drain();

      // random phases with different settings and idling
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 63) : 0;
         receiver_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 63) : 0;
         write_csr(REG_GOAL_TOL, (ph == 0) ? 65535 : $urandom_range(2000));
         write_csr(REG_OBST_THR, $urandom_range(700));
         write_csr(REG_CRUISE, $urandom_range(4095));
         write_csr(REG_TURN_LIM, (ph == 2) ? 16384 : $urandom_range(20000));
         write_csr(REG_LOOKAHEAD, $urandom_range(3000));
         for (int k = 0; k < 4; k++) begin
            queue_path_run($urandom_range(2, 12), $urandom_range(4, 10), 1500);
            if ($urandom_range(4) == 0)
               queue_word(mode_type'($urandom_range(3)), $urandom, $urandom, $urandom,
                          $urandom, $urandom);
         end
         drain();
      end

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_steer.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: sim.f
design/lpf_pkg.sv
design/lpf_ram.sv
design/lookahead_path_follower.sv
verif/tb_lookahead_path_follower.sv
